FILE: design/ssng_pkg.sv
// Shared constants, tables and types of the sphere sprite normal generator.
package ssng_pkg;

  localparam int COORD_BITS_DEF = 8;
  localparam int FIELD_W        = 8;
  localparam int NORM_W         = 16;

  localparam logic [FIELD_W-1:0] DIAM_RESET = 8'd16;

  // floor(x/5) for x below 2^16
  localparam int             DIV5_W     = 16;
  localparam logic [15:0]    DIV5_MULT  = 16'd52429;
  localparam int             DIV5_SHIFT = 18;

  localparam int NX_SHIFT   = 15;
  localparam int ROOT_SHIFT = 32;
  localparam int QBITS      = 17;

  localparam int             HP_W        = 29;
  localparam logic [28:0]    HALF_PI_Q28 = 29'd421657428;
  localparam int             THETA_SHIFT = 16;
  localparam int             THETA_W     = 30;
  localparam int             Q28_SHIFT   = 28;
  localparam int             X2_W        = 31;
  localparam int             TERM_W      = 30;
  localparam int             P_W         = 31;
  localparam int             RECIP_W     = 32;
  localparam int             C_W         = 32;
  localparam int             Z_SHIFT     = 14;
  localparam int             ONE_Q28     = 268435456;
  localparam int             ROUND_HALF  = 8192;
  localparam int             TERMS       = 8;

  // divisor (2k-1)(2k) = 2^TAY_EXP * odd; odd division by reciprocal TAY_MULT >> (P_W+TAY_LOG)
  localparam int TAY_EXP [TERMS] = '{1, 2, 1, 3, 1, 2, 1, 4};
  localparam int TAY_LOG [TERMS] = '{0, 2, 4, 3, 6, 6, 7, 4};
  localparam logic [RECIP_W-1:0] TAY_MULT [TERMS] = '{
    32'd2147483648, 32'd2863311531, 32'd2290649225, 32'd2454267027,
    32'd3054198967, 32'd4164816772, 32'd3020636341, 32'd2290649225
  };

  typedef struct packed {
    logic              outside;
    logic              vis;
    logic [NORM_W-1:0] nx;
    logic [NORM_W-1:0] ny;
  } side_t;

endpackage

FILE: design/sphere_sprite_normal_generator.sv
// Top level of the sphere sprite normal generator.
// Takes one pixel word per clock while the result side does not stall and returns one
// result word per pixel, in order. The pipeline runs through the square root (one bit
// per stage), the divider for t = r/d (one bit per stage) and the eight-term cosine
// series (multiply and reciprocal stages per term).
// A stall on the result side freezes the whole pipeline; one pixel word is held
// in a skid register so that pixel_stall is a register output. The diameter
// is sampled as a pixel enters and must only be written while the block is idle.
module sphere_sprite_normal_generator #(
  parameter int COORD_BITS = ssng_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 pixel_valid,
  output logic                                 pixel_stall,
  input  logic [ssng_pkg::FIELD_W-1:0]         pixel_column,
  input  logic [ssng_pkg::FIELD_W-1:0]         pixel_row,
  output logic                                 normal_valid,
  input  logic                                 normal_stall,
  output logic                                 visible,
  output logic                                 outside_frame,
  output logic signed [ssng_pkg::NORM_W-1:0]   normal_x,
  output logic signed [ssng_pkg::NORM_W-1:0]   normal_y,
  output logic signed [ssng_pkg::NORM_W-1:0]   normal_z,
  input  logic                                 diameter_valid,
  output logic                                 diameter_ready,
  input  logic [ssng_pkg::FIELD_W-1:0]         diameter
);
  import ssng_pkg::*;

  localparam int CW   = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int SW   = 2 * CW + 1;
  localparam int DVW  = CW + 1;
  localparam int NMW  = DVW + QBITS;
  localparam int RB   = (SW + ROOT_SHIFT + 1) / 2;
  localparam int RSBW = 4 + CW + 2 * NMW;
  localparam int MPW  = TERM_W + X2_W;
  localparam int QPW  = P_W + RECIP_W;
  localparam int TPW  = QBITS + HP_W;

  // config register
  logic [FIELD_W-1:0] diam_reg;
  assign diameter_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      diam_reg <= DIAM_RESET;
    end else if (diameter_valid && diameter_ready) begin
      diam_reg <= diameter;
    end
  end

  // global advance and input skid
  logic          en;
  logic          acc;
  logic          skid_valid;
  logic [CW-1:0] skid_col;
  logic [CW-1:0] skid_row;
  logic          feed_vld;
  logic [CW-1:0] feed_col;
  logic [CW-1:0] feed_row;

  assign en          = !(normal_valid && normal_stall);
  assign acc         = pixel_valid && !skid_valid;
  assign pixel_stall = skid_valid;
  assign feed_vld    = skid_valid || acc;
  assign feed_col    = skid_valid ? skid_col : pixel_column[CW-1:0];
  assign feed_row    = skid_valid ? skid_row : pixel_row[CW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (en) begin
      skid_valid <= 1'b0;
    end else if (acc) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && acc) begin
      skid_col <= pixel_column[CW-1:0];
      skid_row <= pixel_row[CW-1:0];
    end
  end

  // stage 1: capture
  logic          s1_vld;
  logic [CW-1:0] s1_col;
  logic [CW-1:0] s1_row;
  logic [CW-1:0] s1_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= feed_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_col <= feed_col;
      s1_row <= feed_row;
      s1_d   <= diam_reg[CW-1:0];
    end
  end

  // stage 2: frame test and offsets
  logic [CW+17:0] h_prod;
  logic [CW-1:0]  height;
  logic [CW+1:0]  dx_w;
  logic [CW+3:0]  dy_w;
  logic           s2_vld;
  logic           s2_out;
  logic [CW:0]    s2_dx;
  logic [CW:0]    s2_dy;
  logic [CW-1:0]  s2_d;

  assign h_prod = (CW+18)'({s1_d, 1'b0}) * (CW+18)'(DIV5_MULT);
  assign height = h_prod[DIV5_SHIFT +: CW];
  assign dx_w   = (CW+2)'({s1_col, 1'b1}) - (CW+2)'(s1_d);
  assign dy_w   = (CW+4)'({s1_row, 2'b00}) + (CW+4)'(s1_row) + (CW+4)'(3) - (CW+4)'(s1_d);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_out <= (s1_col >= s1_d) || (s1_row >= height);
      s2_dx  <= dx_w[CW:0];
      s2_dy  <= dy_w[CW:0];
      s2_d   <= s1_d;
    end
  end

  // stage 3: magnitudes and squared radius
  logic [CW:0]     ax;
  logic [CW:0]     ay;
  logic [CW-1:0]   magx;
  logic [CW-1:0]   magy;
  logic            s3_vld;
  logic            s3_out;
  logic            s3_sgnx;
  logic            s3_sgny;
  logic [CW-1:0]   s3_magx;
  logic [CW-1:0]   s3_magy;
  logic [CW-1:0]   s3_d;
  logic [SW-1:0]   s3_s;
  logic [2*CW-1:0] s3_dsq;

  assign ax   = s2_dx[CW] ? -s2_dx : s2_dx;
  assign ay   = s2_dy[CW] ? -s2_dy : s2_dy;
  assign magx = ax[CW-1:0];
  assign magy = ay[CW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (en) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_out  <= s2_out;
      s3_sgnx <= s2_dx[CW];
      s3_sgny <= s2_dy[CW];
      s3_magx <= magx;
      s3_magy <= magy;
      s3_d    <= s2_d;
      s3_s    <= SW'(magx) * SW'(magx) + SW'(magy) * SW'(magy);
      s3_dsq  <= (2*CW)'(s2_d) * (2*CW)'(s2_d);
    end
  end

  // stage 4: outline test and divider numerators
  logic           s4_vld;
  logic           s4_out;
  logic           s4_vis;
  logic           s4_sgnx;
  logic           s4_sgny;
  logic [CW-1:0]  s4_d;
  logic [SW-1:0]  s4_s;
  logic [NMW-1:0] s4_numx;
  logic [NMW-1:0] s4_numy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (en) begin
      s4_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_out  <= s3_out;
      s4_vis  <= (s3_s < {1'b0, s3_dsq});
      s4_sgnx <= s3_sgnx;
      s4_sgny <= s3_sgny;
      s4_d    <= s3_d;
      s4_s    <= s3_s;
      s4_numx <= NMW'({s3_magx, {NX_SHIFT{1'b0}}}) + NMW'(s3_d);
      s4_numy <= NMW'({s3_magy, {NX_SHIFT{1'b0}}}) + NMW'(s3_d);
    end
  end

  // radial distance r = sqrt(s) in Q16
  logic            rt_vld;
  logic [RB-1:0]   rt_root;
  logic [RSBW-1:0] rt_sb;
  logic            rt_out;
  logic            rt_vis;
  logic            rt_sgnx;
  logic            rt_sgny;
  logic [CW-1:0]   rt_d;
  logic [NMW-1:0]  rt_numx;
  logic [NMW-1:0]  rt_numy;

  ssng_root #(
    .IW  (SW),
    .SBW (RSBW)
  ) u_root (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (s4_vld),
    .in_val  (s4_s),
    .in_sb   ({s4_out, s4_vis, s4_sgnx, s4_sgny, s4_d, s4_numx, s4_numy}),
    .out_vld (rt_vld),
    .root    (rt_root),
    .out_sb  (rt_sb)
  );

  assign {rt_out, rt_vis, rt_sgnx, rt_sgny, rt_d, rt_numx, rt_numy} = rt_sb;

  // three dividers in lockstep: t = r/d, x and y normals
  logic             tdiv_vld;
  logic             xdiv_vld;
  logic             ydiv_vld;
  logic [QBITS-1:0] tq;
  logic [QBITS-1:0] qx;
  logic [QBITS-1:0] qy;
  logic [1:0]       tdiv_sb;
  logic             xdiv_sb;
  logic             ydiv_sb;

  ssng_div #(
    .DW  (DVW),
    .QB  (QBITS),
    .SBW (2)
  ) u_tdiv (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (rt_vld),
    .numer   (NMW'(rt_root)),
    .denom   ({1'b0, rt_d}),
    .in_sb   ({rt_out, rt_vis}),
    .out_vld (tdiv_vld),
    .quo     (tq),
    .out_sb  (tdiv_sb)
  );

  ssng_div #(
    .DW  (DVW),
    .QB  (QBITS),
    .SBW (1)
  ) u_xdiv (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (rt_vld),
    .numer   (rt_numx),
    .denom   ({rt_d, 1'b0}),
    .in_sb   (rt_sgnx),
    .out_vld (xdiv_vld),
    .quo     (qx),
    .out_sb  (xdiv_sb)
  );

  ssng_div #(
    .DW  (DVW),
    .QB  (QBITS),
    .SBW (1)
  ) u_ydiv (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (rt_vld),
    .numer   (rt_numy),
    .denom   ({rt_d, 1'b0}),
    .in_sb   (rt_sgny),
    .out_vld (ydiv_vld),
    .quo     (qy),
    .out_sb  (ydiv_sb)
  );

  // T1: theta product, signed x/y normals
  logic [NORM_W-1:0] qx_ext;
  logic [NORM_W-1:0] qy_ext;
  logic              t1_vld;
  logic [TPW-1:0]    t1_prod;
  side_t             t1_side;

  assign qx_ext = qx[NORM_W-1:0];
  assign qy_ext = qy[NORM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_vld <= 1'b0;
    end else if (en) begin
      t1_vld <= tdiv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_prod <= TPW'(tq) * TPW'(HALF_PI_Q28);
      t1_side <= '{outside: tdiv_sb[1],
                   vis:     tdiv_sb[0],
                   nx:      xdiv_sb ? -qx_ext : qx_ext,
                   ny:      ydiv_sb ? -qy_ext : qy_ext};
    end
  end

  // T2: theta squared
  logic [THETA_W-1:0]   theta;
  logic                 t2_vld;
  logic [2*THETA_W-1:0] t2_sq;
  side_t                t2_side;

  assign theta = t1_prod[THETA_SHIFT +: THETA_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      t2_vld <= 1'b0;
    end else if (en) begin
      t2_vld <= t1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2_sq   <= (2*THETA_W)'(theta) * (2*THETA_W)'(theta);
      t2_side <= t1_side;
    end
  end

  // cosine series: per term a multiply stage and a reciprocal stage
  logic                  m_vld  [TERMS];
  logic [MPW-1:0]        m_prod [TERMS];
  logic [X2_W-1:0]       m_x2   [TERMS];
  logic signed [C_W-1:0] m_c    [TERMS];
  side_t                 m_side [TERMS];
  logic                  d_vld  [TERMS];
  logic [TERM_W-1:0]     d_term [TERMS];
  logic [X2_W-1:0]       d_x2   [TERMS];
  logic signed [C_W-1:0] d_c    [TERMS];
  side_t                 d_side [TERMS];

  genvar g;
  for (g = 0; g < TERMS; g++) begin : g_term
    logic                  c_vld;
    logic [TERM_W-1:0]     c_term;
    logic [X2_W-1:0]       c_x2;
    logic signed [C_W-1:0] c_acc;
    side_t                 c_side;
    logic [MPW-1:0]        sh;
    logic [P_W-1:0]        p;
    logic [QPW-1:0]        qp;
    logic [QPW-1:0]        qsh;

    if (g == 0) begin : g_first
      assign c_vld  = t2_vld;
      assign c_term = TERM_W'(ONE_Q28);
      assign c_x2   = t2_sq[Q28_SHIFT +: X2_W];
      assign c_acc  = C_W'(ONE_Q28);
      assign c_side = t2_side;
    end else begin : g_next
      logic signed [C_W-1:0] prev;
      assign prev   = $signed({{(C_W-TERM_W){1'b0}}, d_term[g-1]});
      assign c_vld  = d_vld[g-1];
      assign c_term = d_term[g-1];
      assign c_x2   = d_x2[g-1];
      // odd-numbered terms subtract
      assign c_acc  = (g % 2 == 1) ? (d_c[g-1] - prev) : (d_c[g-1] + prev);
      assign c_side = d_side[g-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        m_vld[g] <= 1'b0;
        d_vld[g] <= 1'b0;
      end else if (en) begin
        m_vld[g] <= c_vld;
        d_vld[g] <= m_vld[g];
      end
    end

    assign sh  = m_prod[g] >> (Q28_SHIFT + TAY_EXP[g]);
    assign p   = sh[P_W-1:0];
    assign qp  = QPW'(p) * QPW'(TAY_MULT[g]);
    assign qsh = qp >> (P_W + TAY_LOG[g]);

    always_ff @(posedge clk) begin
      if (en) begin
        m_prod[g] <= MPW'(c_term) * MPW'(c_x2);
        m_x2[g]   <= c_x2;
        m_c[g]    <= c_acc;
        m_side[g] <= c_side;
        d_term[g] <= qsh[TERM_W-1:0];
        d_x2[g]   <= m_x2[g];
        d_c[g]    <= m_c[g];
        d_side[g] <= m_side[g];
      end
    end
  end

  // final sum, the last term is even and adds
  logic                  f_vld;
  logic signed [C_W-1:0] f_c;
  side_t                 f_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (en) begin
      f_vld <= d_vld[TERMS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_c    <= d_c[TERMS-1] + $signed({{(C_W-TERM_W){1'b0}}, d_term[TERMS-1]});
      f_side <= d_side[TERMS-1];
    end
  end

  // output register with rounding of z
  logic [C_W-1:0]    cmag;
  logic [C_W-1:0]    cround;
  logic [NORM_W-1:0] zmag;
  logic [NORM_W-1:0] zval;

  assign cmag   = f_c[C_W-1] ? -f_c : f_c;
  assign cround = cmag + C_W'(ROUND_HALF);
  assign zmag   = cround[Z_SHIFT +: NORM_W];
  assign zval   = f_c[C_W-1] ? -zmag : zmag;

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_valid <= 1'b0;
    end else if (en) begin
      normal_valid <= f_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      outside_frame <= f_side.outside;
      visible       <= f_side.vis && !f_side.outside;
      normal_x      <= f_side.outside ? '0 : f_side.nx;
      normal_y      <= f_side.outside ? '0 : f_side.ny;
      normal_z      <= f_side.outside ? '0 : zval;
    end
  end

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    (tdiv_vld == xdiv_vld) && (tdiv_vld == ydiv_vld))
    else $error("dividers out of step");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> !$past(en))
    else $error("skid filled while pipeline advancing");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (normal_valid && outside_frame) |->
      (!visible && normal_x == '0 && normal_y == '0 && normal_z == '0))
    else $error("outside-frame word carries nonzero result");

endmodule

FILE: design/ssng_root.sv
// Pipelined integer square root of (value << ROOT_SHIFT), one result bit per stage.
module ssng_root #(
  parameter int IW  = 17,
  parameter int SBW = 1
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      en,
  input  logic                                      in_vld,
  input  logic [IW-1:0]                             in_val,
  input  logic [SBW-1:0]                            in_sb,
  output logic                                      out_vld,
  output logic [(IW+ssng_pkg::ROOT_SHIFT+1)/2-1:0]  root,
  output logic [SBW-1:0]                            out_sb
);
  import ssng_pkg::*;

  localparam int RB = (IW + ROOT_SHIFT + 1) / 2;
  localparam int NW = 2 * RB;

  logic           vld [RB];
  logic [NW-1:0]  rem [RB];
  logic [NW-1:0]  res [RB];
  logic [SBW-1:0] sb  [RB];

  genvar k;
  for (k = 0; k < RB; k++) begin : g_stage
    localparam logic [NW-1:0] BIT = NW'(1) << (2 * (RB - 1 - k));
    logic           c_vld;
    logic [NW-1:0]  c_rem;
    logic [NW-1:0]  c_res;
    logic [SBW-1:0] c_sb;
    logic [NW-1:0]  trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign c_vld = in_vld;
      assign c_rem = NW'(in_val) << ROOT_SHIFT;
      assign c_res = '0;
      assign c_sb  = in_sb;
    end else begin : g_next
      assign c_vld = vld[k-1];
      assign c_rem = rem[k-1];
      assign c_res = res[k-1];
      assign c_sb  = sb[k-1];
    end

    assign trial = c_res + BIT;
    assign ge    = (c_rem >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= c_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? (c_rem - trial) : c_rem;
        res[k] <= ge ? ((c_res >> 1) + BIT) : (c_res >> 1);
        sb[k]  <= c_sb;
      end
    end
  end

  assign out_vld = vld[RB-1];
  assign root    = res[RB-1][RB-1:0];
  assign out_sb  = sb[RB-1];

endmodule

FILE: design/ssng_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module ssng_div #(
  parameter int DW  = 9,
  parameter int QB  = 17,
  parameter int SBW = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  logic [DW+QB-1:0] numer,
  input  logic [DW-1:0]    denom,
  input  logic [SBW-1:0]   in_sb,
  output logic             out_vld,
  output logic [QB-1:0]    quo,
  output logic [SBW-1:0]   out_sb
);
  import ssng_pkg::*;

  localparam int RW = DW + QB;

  logic           vld [QB];
  logic [RW-1:0]  rem [QB];
  logic [QB-1:0]  q   [QB];
  logic [DW-1:0]  den [QB];
  logic [SBW-1:0] sb  [QB];

  genvar k;
  for (k = 0; k < QB; k++) begin : g_stage
    logic           c_vld;
    logic [RW-1:0]  c_rem;
    logic [QB-1:0]  c_q;
    logic [DW-1:0]  c_den;
    logic [SBW-1:0] c_sb;
    logic [RW-1:0]  sub;
    logic           ge;

    if (k == 0) begin : g_first
      assign c_vld = in_vld;
      assign c_rem = numer;
      assign c_q   = '0;
      assign c_den = denom;
      assign c_sb  = in_sb;
    end else begin : g_next
      assign c_vld = vld[k-1];
      assign c_rem = rem[k-1];
      assign c_q   = q[k-1];
      assign c_den = den[k-1];
      assign c_sb  = sb[k-1];
    end

    assign sub = RW'(c_den) << (QB - 1 - k);
    assign ge  = (c_rem >= sub);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= c_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? (c_rem - sub) : c_rem;
        q[k]   <= c_q | ({{(QB-1){1'b0}}, ge} << (QB - 1 - k));
        den[k] <= c_den;
        sb[k]  <= c_sb;
      end
    end
  end

  assign out_vld = vld[QB-1];
  assign quo     = q[QB-1];
  assign out_sb  = sb[QB-1];

endmodule
